// ===== hdl/ads_pkg.sv =====
// Shared types, constants and the microprogram for the audio distortion shaper.
// Used by ads_datapath and audio_distortion_shaper; depends on nothing else.
package ads_pkg;

    // Field and register widths.
    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 3;
    localparam int GAIN_W     = 8;
    localparam int THR_W      = 15;
    localparam int CRUSH_W    = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 15;

    // Working value width: holds sample times gain and every fold reflection.
    localparam int ACC_W  = 26;
    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 17;
    localparam int PROD_W = 2 * MUL_W;

    localparam int Q15_SHIFT   = 15;
    localparam int RECIP_SHIFT = 16;
    localparam logic signed [MUL_W-1:0] CUBIC_RECIP = MUL_W'(21846);

    localparam int FOLD_STEPS = 8;
    localparam int FOLD_CNT_W = $clog2(FOLD_STEPS + 1);

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_THR   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CRUSH = CFG_IDX_W'(3);

    // Mode register codes.
    localparam logic [MODE_W-1:0] MODE_BYPASS = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_HARD   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_SOFT   = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_FOLD   = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_CRUSH  = MODE_W'(4);

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_GAIN,
        OP_SAT,
        OP_SQR,
        OP_CUBE,
        OP_RECIP,
        OP_SUB,
        OP_FOLD,
        OP_CRUSH
    } t_op;

    // Sequencer jump conditions.
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_DISPATCH,
        JC_FOLD_MORE
    } t_jc;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // Program addresses.
    localparam t_pc PC_DISPATCH  = PC_W'(0);
    localparam t_pc PC_BYPASS    = PC_W'(1);
    localparam t_pc PC_HARD      = PC_W'(2);
    localparam t_pc PC_SOFT      = PC_W'(4);
    localparam t_pc PC_FOLD      = PC_W'(10);
    localparam t_pc PC_FOLD_LOOP = PC_W'(11);
    localparam t_pc PC_CRUSH     = PC_W'(13);
    localparam t_pc PC_LAST      = PC_CRUSH;

    typedef struct packed {
        t_op  op;
        t_jc  jc;
        t_pc  target;
        logic last;
    } t_ctrl;

    typedef struct packed {
        logic fold_more;
    } t_dp_status;

    function automatic t_ctrl mk(t_op op, t_jc jc, t_pc target, logic last);
        t_ctrl c;
        c.op     = op;
        c.jc     = jc;
        c.target = target;
        c.last   = last;
        return c;
    endfunction

    // Microprogram ROM: one control word per step.
    function automatic t_ctrl rom(t_pc pc);
        t_ctrl c;
        case (pc)
            PC_W'(0):  c = mk(OP_NOP,      JC_DISPATCH,  PC_DISPATCH,  1'b0);
            PC_W'(1):  c = mk(OP_NOP,      JC_NEXT,      PC_DISPATCH,  1'b1);
            PC_W'(2):  c = mk(OP_MUL_GAIN, JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(3):  c = mk(OP_SAT,      JC_NEXT,      PC_DISPATCH,  1'b1);
            PC_W'(4):  c = mk(OP_MUL_GAIN, JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(5):  c = mk(OP_SAT,      JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(6):  c = mk(OP_SQR,      JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(7):  c = mk(OP_CUBE,     JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(8):  c = mk(OP_RECIP,    JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(9):  c = mk(OP_SUB,      JC_NEXT,      PC_DISPATCH,  1'b1);
            PC_W'(10): c = mk(OP_MUL_GAIN, JC_NEXT,      PC_DISPATCH,  1'b0);
            PC_W'(11): c = mk(OP_FOLD,     JC_FOLD_MORE, PC_FOLD_LOOP, 1'b0);
            PC_W'(12): c = mk(OP_SAT,      JC_NEXT,      PC_DISPATCH,  1'b1);
            PC_W'(13): c = mk(OP_CRUSH,    JC_NEXT,      PC_DISPATCH,  1'b1);
            default:   c = mk(OP_NOP,      JC_NEXT,      PC_DISPATCH,  1'b1);
        endcase
        return c;
    endfunction

    // Entry address for each mode; unused codes run the bypass routine.
    function automatic t_pc entry(logic [MODE_W-1:0] mode);
        t_pc p;
        case (mode)
            MODE_HARD:  p = PC_HARD;
            MODE_SOFT:  p = PC_SOFT;
            MODE_FOLD:  p = PC_FOLD;
            MODE_CRUSH: p = PC_CRUSH;
            default:    p = PC_BYPASS;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/ads_datapath.sv =====
// Datapath of the audio distortion shaper: working registers, one shared multiplier,
// saturation, fold reflection and bit masking. Depends on ads_pkg.
module ads_datapath import ads_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic                       i_step,
    input  t_ctrl                      i_ctrl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [GAIN_W-1:0]          i_gain,
    input  logic [THR_W-1:0]           i_thr,
    input  logic [CRUSH_W-1:0]         i_crush,
    output t_dp_status                 o_status,
    output logic [SAMPLE_W-1:0]        o_result
);

    logic signed [SAMPLE_W-1:0] r_s;
    logic signed [ACC_W-1:0]    r_x, n_x;
    logic signed [MUL_W-1:0]    r_y, n_y;
    logic [FOLD_CNT_W-1:0]      r_cnt, n_cnt;

    logic signed [MUL_W-1:0]  mul_a, mul_b, x17;
    logic signed [PROD_W-1:0] prod, sh15, sh16;
    logic signed [ACC_W-1:0]  thr, two_thr, sat_x;
    logic [SAMPLE_W-1:0]      crushed;
    logic                     above, below;

    assign x17     = {r_x[SAMPLE_W-1], r_x[SAMPLE_W-1:0]};
    assign thr     = $signed({{(ACC_W - THR_W){1'b0}}, i_thr});
    assign two_thr = $signed({{(ACC_W - THR_W - 1){1'b0}}, i_thr, 1'b0});
    assign above   = r_x > thr;
    assign below   = r_x < -thr;
    assign o_status.fold_more = (above || below) && (r_cnt < FOLD_CNT_W'(FOLD_STEPS));

    assign sat_x = (r_x > SAT_HI) ? SAT_HI : ((r_x < SAT_LO) ? SAT_LO : r_x);
    assign crushed = r_s & ({SAMPLE_W{1'b1}} << i_crush);

    always_comb begin
        case (i_ctrl.op)
            OP_MUL_GAIN: begin
                mul_a = {r_s[SAMPLE_W-1], r_s};
                mul_b = $signed({{(MUL_W - GAIN_W){1'b0}}, i_gain});
            end
            OP_SQR: begin
                mul_a = x17;
                mul_b = x17;
            end
            OP_CUBE: begin
                mul_a = r_y;
                mul_b = x17;
            end
            OP_RECIP: begin
                mul_a = r_y;
                mul_b = CUBIC_RECIP;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign sh15 = prod >>> Q15_SHIFT;
    assign sh16 = prod >>> RECIP_SHIFT;

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_cnt = r_cnt;
        if (i_load) begin
            n_x = ACC_W'(i_sample);
        end else if (i_step) begin
            case (i_ctrl.op)
                OP_MUL_GAIN: begin
                    n_x   = prod[ACC_W-1:0];
                    n_cnt = '0;
                end
                OP_SAT:   n_x = sat_x;
                OP_SQR:   n_y = sh15[MUL_W-1:0];
                OP_CUBE:  n_y = sh15[MUL_W-1:0];
                OP_RECIP: n_y = sh16[MUL_W-1:0];
                OP_SUB:   n_x = r_x - ACC_W'(r_y);
                OP_FOLD: begin
                    if (o_status.fold_more) begin
                        n_x   = above ? (two_thr - r_x) : (-two_thr - r_x);
                        n_cnt = r_cnt + FOLD_CNT_W'(1);
                    end
                end
                OP_CRUSH: n_x = ACC_W'($signed(crushed));
                default:  n_x = r_x;
            endcase
        end
    end

    assign o_result = n_x[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= i_sample;
        end
        r_x <= n_x;
        r_y <= n_y;
    end

    // The fold loop never runs past its step budget.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FOLD_CNT_W'(FOLD_STEPS))
        else $error("fold step count beyond limit");

endmodule

// ===== hdl/audio_distortion_shaper.sv =====
// Audio distortion shaper, top level: microcode sequencer, configuration registers
// and result register. Depends on ads_pkg and ads_datapath.
// Each accepted sample runs the dispatch step and then its mode's routine; the final value is
// registered on o_sample_out as o_valid rises. Foldback repeats its reflection step as needed.
// The sequencer steps once per cycle while busy is high; a new request is taken only while
// busy is low, so no sample is accepted before the previous one's result is registered.
// Synchronous active-low reset clears the sequencer and loads the register defaults.
// The result strobe lasts one cycle; the receiver cannot stall, so nothing is held back.
module audio_distortion_shaper import ads_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Sample request channel.
    input  logic                       start,
    output logic                       busy,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    // Result strobe.
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    // Configuration write channel.
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    logic [MODE_W-1:0]  r_mode;
    logic [GAIN_W-1:0]  r_gain;
    logic [THR_W-1:0]   r_thr;
    logic [CRUSH_W-1:0] r_crush;

    logic r_busy, n_busy;
    t_pc  r_pc, n_pc;
    logic r_valid;
    logic [SAMPLE_W-1:0] r_out;

    t_ctrl              ctrl;
    t_dp_status         status;
    logic               load;
    logic [SAMPLE_W-1:0] result;

    // Configuration writes are always taken; the user must write only while the block is idle (not enforced here).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_BYPASS;
            r_gain  <= GAIN_W'(1);
            r_thr   <= THR_W'(16384);
            r_crush <= CRUSH_W'(4);
        end else if (i_cfg_valid) begin
            // Only each register's width is kept; unknown indexes are dropped.
            case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                REG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_THR:   r_thr   <= i_cfg_data[THR_W-1:0];
                REG_CRUSH: r_crush <= i_cfg_data[CRUSH_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // A request is taken only while the sequencer is parked.
    assign busy = r_busy;
    assign load = start && !r_busy;
    assign ctrl = rom(r_pc);

    // Next microinstruction address: mode dispatch, fold loop, fall through or program end.
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (load) begin
            n_busy = 1'b1;
            n_pc   = PC_DISPATCH;
        end else if (r_busy) begin
            if (ctrl.last) begin
                n_busy = 1'b0;
                n_pc   = PC_DISPATCH;
            end else begin
                case (ctrl.jc)
                    JC_DISPATCH:  n_pc = entry(r_mode);
                    JC_FOLD_MORE: n_pc = status.fold_more ? ctrl.target : r_pc + PC_W'(1);
                    default:      n_pc = r_pc + PC_W'(1);
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pc    <= PC_DISPATCH;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= n_busy;
            r_pc    <= n_pc;
            r_valid <= r_busy && ctrl.last;
        end
    end

    // The final step's datapath value is captured as the result.
    always_ff @(posedge i_clk) begin
        if (r_busy && ctrl.last) begin
            r_out <= result;
        end
    end

    assign o_valid      = r_valid;
    assign o_sample_out = $signed(r_out);

    ads_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_step   (r_busy),
        .i_ctrl   (ctrl),
        .i_sample (i_sample_in),
        .i_gain   (r_gain),
        .i_thr    (r_thr),
        .i_crush  (r_crush),
        .o_status (status),
        .o_result (result)
    );

    // A result strobe follows the last busy cycle of its sample.
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!r_busy || r_pc == PC_DISPATCH) && $past(r_busy))
        else $error("result strobe without a finished sample");

    // An accepted request starts the program at the dispatch step.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && r_pc == PC_DISPATCH))
        else $error("accepted request did not start the sequencer");

    // The program counter stays inside the microprogram.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= PC_LAST)
        else $error("program counter out of range");

    // One request yields a single-cycle strobe.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule
